// File: design/crcpf_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the packet framer.
package crcpf_pkg;

    localparam logic [15:0] MAX_PAYLOAD = 16'd1024;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_TOP     = 16'h8000;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_FIRST      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_SECOND     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL_VERSION = 2'd2;

    typedef logic [3:0] idx_t;

    // result positions within a start transaction
    localparam idx_t HDR_LAST_IDX = 4'd11;
    localparam idx_t HDR_CRC_LO   = 4'd12;
    localparam idx_t HDR_CRC_HI   = 4'd13;
    // result positions within a payload transaction
    localparam idx_t PAY_CRC_LO   = 4'd1;
    localparam idx_t PAY_CRC_HI   = 4'd2;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } op_t;

    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] data;
    } crc_ctl_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: design/crcpf_crc_unit.sv
// Running CRC-16/CCITT-FALSE register with one-byte-per-cycle update.
module crcpf_crc_unit
    import crcpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctl_t    ctl,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.clear)
            crc_next = CRC_INIT;
        else if (ctl.feed)
            crc_next = crc_feed(crc_reg, ctl.data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

    a_clear_wins: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> crc_reg == CRC_INIT)
        else $error("crc not reinitialized after clear");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.clear && !ctl.feed |=> $stable(crc_reg))
        else $error("crc changed without feed");

    a_feed: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.clear && ctl.feed |=> crc_reg == crc_feed($past(crc_reg), $past(ctl.data)))
        else $error("crc update mismatch");

endmodule

// File: design/crc_packet_framer_unit.sv
// Top level of the packet framer: input register, result sequencer and output register.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction: op 0 starts a frame
//   with frame_type, data_length, sequence_number and timestamp; op 1 carries
//   one payload_byte. Output channel (out_valid/out_ready) delivers one byte per
//   transaction with last on the final byte caused by an input and error on the
//   single result of a rejected input. cfg_wr_en writes magic and version bytes.
//   An accepted input enters the input register, its first result then the
//   output register. Throughput: one output byte per cycle unless the receiver
//   stalls. A payload byte gives one result, the final one also both CRC bytes;
//   a start the header bytes up to the timestamp, plus the header CRC at zero
//   length; an error one result. The output stream is the limit: the next input
//   is accepted in the same cycle the current one's last byte is registered.
//   Reset: no frame open, CRC at 0xFFFF, config registers zero, channels empty.
//   Receiver stall: the output register holds its byte; the held input waits and
//   in_ready drops once an input is already held.
module crc_packet_framer_unit
    import crcpf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic [7:0]             frame_type,
    input  logic [15:0]            data_length,
    input  logic [15:0]            sequence_number,
    input  logic [31:0]            timestamp,
    input  logic [7:0]             payload_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   last,
    output logic                   error
);

    logic [7:0]  magic_first_reg;
    logic [7:0]  magic_second_reg;
    logic [7:0]  version_reg;

    logic        cur_valid_reg;
    logic        cur_valid_next;
    op_t         cur_op_reg;
    logic [7:0]  cur_type_reg;
    logic [15:0] cur_len_reg;
    logic [15:0] cur_seq_reg;
    logic [31:0] cur_ts_reg;
    logic [7:0]  cur_byte_reg;
    idx_t        idx_reg;
    idx_t        idx_next;

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_error_reg;

    logic        gen;
    logic        accept;
    logic [7:0]  res_byte;
    logic        res_last;
    logic        res_error;
    logic [15:0] crc;
    crc_ctl_t    crc_ctl;

    crcpf_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .crc   (crc)
    );

    assign gen      = cur_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !cur_valid_reg || (gen && res_last);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            magic_first_reg  <= 8'h00;
            magic_second_reg <= 8'h00;
            version_reg      <= 8'h00;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAGIC_FIRST:      magic_first_reg  <= cfg_data;
                CFG_MAGIC_SECOND:     magic_second_reg <= cfg_data;
                CFG_PROTOCOL_VERSION: version_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // result for the current transaction at position idx_reg
    always_comb
    begin
        res_byte        = 8'h00;
        res_last        = 1'b0;
        res_error       = 1'b0;
        crc_ctl         = '0;
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;

        if (cur_op_reg == OP_START) begin
            if (cur_len_reg > MAX_PAYLOAD) begin
                res_last        = 1'b1;
                res_error       = 1'b1;
                crc_ctl.clear   = 1'b1;
                frame_open_next = 1'b0;
                bytes_left_next = 16'h0000;
            end else begin
                case (idx_reg)
                    4'd0:       res_byte = magic_first_reg;
                    4'd1:       res_byte = magic_second_reg;
                    4'd2:       res_byte = version_reg;
                    4'd3:       res_byte = cur_type_reg;
                    4'd4:       res_byte = cur_len_reg[7:0];
                    4'd5:       res_byte = cur_len_reg[15:8];
                    4'd6:       res_byte = cur_seq_reg[7:0];
                    4'd7:       res_byte = cur_seq_reg[15:8];
                    4'd8:       res_byte = cur_ts_reg[7:0];
                    4'd9:       res_byte = cur_ts_reg[15:8];
                    4'd10:      res_byte = cur_ts_reg[23:16];
                    4'd11:      res_byte = cur_ts_reg[31:24];
                    HDR_CRC_LO: res_byte = crc[7:0];
                    HDR_CRC_HI: res_byte = crc[15:8];
                    default:    res_byte = 8'h00;
                endcase
                crc_ctl.data = res_byte;
                crc_ctl.feed = (idx_reg >= 4'd2) && (idx_reg <= HDR_LAST_IDX);
                if (idx_reg == 4'd0) begin
                    crc_ctl.clear   = 1'b1;
                    frame_open_next = 1'b0;
                    bytes_left_next = 16'h0000;
                end
                if (cur_len_reg == 16'h0000) begin
                    res_last      = (idx_reg == HDR_CRC_HI);
                    crc_ctl.clear = crc_ctl.clear || (idx_reg == HDR_CRC_HI);
                end else if (idx_reg == HDR_LAST_IDX) begin
                    res_last        = 1'b1;
                    frame_open_next = 1'b1;
                    bytes_left_next = cur_len_reg;
                end
            end
        end else begin
            case (idx_reg)
                PAY_CRC_LO:
                begin
                    res_byte = crc[7:0];
                end
                PAY_CRC_HI:
                begin
                    res_byte      = crc[15:8];
                    res_last      = 1'b1;
                    crc_ctl.clear = 1'b1;
                end
                default:
                begin
                    if (!frame_open_reg || bytes_left_reg == 16'h0000) begin
                        res_last  = 1'b1;
                        res_error = 1'b1;
                    end else begin
                        res_byte        = cur_byte_reg;
                        crc_ctl.feed    = 1'b1;
                        crc_ctl.data    = cur_byte_reg;
                        bytes_left_next = bytes_left_reg - 16'd1;
                        if (bytes_left_reg == 16'd1)
                            frame_open_next = 1'b0;
                        else
                            res_last = 1'b1;
                    end
                end
            endcase
        end

        if (!gen) begin
            crc_ctl         = '0;
            frame_open_next = frame_open_reg;
            bytes_left_next = bytes_left_reg;
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (accept) begin
            cur_valid_next = 1'b1;
            idx_next       = 4'd0;
        end else if (gen) begin
            if (res_last)
                cur_valid_next = 1'b0;
            idx_next = idx_reg + 4'd1;
        end

        out_valid_next = out_valid_reg;
        if (gen)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg  <= 1'b0;
            idx_reg        <= 4'd0;
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'h0000;
            out_valid_reg  <= 1'b0;
        end else begin
            cur_valid_reg  <= cur_valid_next;
            idx_reg        <= idx_next;
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cur_op_reg   <= op_t'(op);
            cur_type_reg <= frame_type;
            cur_len_reg  <= data_length;
            cur_seq_reg  <= sequence_number;
            cur_ts_reg   <= timestamp;
            cur_byte_reg <= payload_byte;
        end
        if (gen) begin
            out_byte_reg  <= res_byte;
            out_last_reg  <= res_last;
            out_error_reg <= res_error;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;
    assign error     = out_error_reg;

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_error_reg |-> out_last_reg && out_byte_reg == 8'h00)
        else $error("error result must be last with zero byte");

    a_open_left: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> bytes_left_reg != 16'h0000 && bytes_left_reg <= MAX_PAYLOAD)
        else $error("open frame with bad byte count");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= HDR_CRC_HI)
        else $error("result index out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        gen && res_last && !accept |=> !cur_valid_reg)
        else $error("transaction not retired after last result");

endmodule
